[hdl/assert_macros.svh]
// Assertion helpers shared by the packer modules.
// Both forms check on the rising clock edge and are off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[hdl/asbp_pkg.sv]
package asbp_pkg;

   // Buffer geometry.
   localparam int NUM_BLOCKS   = 4;
   localparam int BLOCK_BYTES  = 512;
   localparam int SAMPLE_BITS  = 32;
   localparam int SAMPLE_BYTES = SAMPLE_BITS / 8;
   localparam int FILL_LIMIT   = BLOCK_BYTES - 8;
   localparam int COUNT_OFFSET = BLOCK_BYTES - 6;

   // Field widths.
   localparam int ADDR_W  = 11;
   localparam int OFF_W   = $clog2(BLOCK_BYTES);
   localparam int BLK_W   = 2;
   localparam int FLAG_W  = 4;
   localparam int COUNT_W = 8;

   localparam logic [OFF_W-1:0] FILL_OFF   = OFF_W'(FILL_LIMIT);
   localparam logic [OFF_W-1:0] COUNT_OFF  = OFF_W'(COUNT_OFFSET);
   localparam logic [OFF_W-1:0] STEP_OFF   = OFF_W'(SAMPLE_BYTES);
   localparam logic [BLK_W-1:0] LAST_BLOCK = BLK_W'(NUM_BLOCKS - 1);

   // Job queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACTION_SAMPLE  = 1'b0,
      ACTION_RELEASE = 1'b1
   } action_type;

   typedef struct packed {
      action_type             action;
      logic [SAMPLE_BITS-1:0] sample;
      logic [BLK_W-1:0]       release_block;
   } req_type;

   typedef struct packed {
      logic                   write_enable;
      logic [ADDR_W-1:0]      write_address;
      logic [SAMPLE_BITS-1:0] write_data;
      logic                   write_is_byte;
      logic                   block_done;
      logic [BLK_W-1:0]       done_block;
      logic [FLAG_W-1:0]      ready_flags;
      logic                   last;
   } rsp_type;

   // One classified word: a sample write, possibly completing a block, or a release.
   typedef struct packed {
      logic                   is_write;
      logic [ADDR_W-1:0]      addr;
      logic [SAMPLE_BITS-1:0] data;
      logic                   done;
      logic [BLK_W-1:0]       blk;
      logic [COUNT_W-1:0]     count;
      logic [FLAG_W-1:0]      flags;
   } job_type;

endpackage

[hdl/asbp_front.sv]
`include "assert_macros.svh"

module asbp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  asbp_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output asbp_pkg::job_type q_job
);

   logic [asbp_pkg::ADDR_W-1:0]     wp_ff, wp_in;
   logic [asbp_pkg::NUM_BLOCKS-1:0] ready_ff, ready_in;
   logic [asbp_pkg::COUNT_W-1:0]    count_ff, count_in;

   logic [asbp_pkg::BLK_W-1:0]   blk;
   logic [asbp_pkg::BLK_W-1:0]   blk_next;
   logic [asbp_pkg::OFF_W-1:0]   off_next;
   logic [asbp_pkg::COUNT_W-1:0] count_inc;
   logic                         completes;

   assign q_push = push && !q_full;

   // Pointer split into block number and offset within the block.
   always_comb begin
      blk       = wp_ff[asbp_pkg::ADDR_W-1:asbp_pkg::OFF_W];
      off_next  = wp_ff[asbp_pkg::OFF_W-1:0] + asbp_pkg::STEP_OFF;
      completes = (off_next >= asbp_pkg::FILL_OFF);
      blk_next  = (blk == asbp_pkg::LAST_BLOCK) ? '0 : blk + 1'b1;
      count_inc = (&ready_ff) ? count_ff + 1'b1 : count_ff;
   end

   // Classify the accepted word and work out the state it leaves behind.
   always_comb begin
      wp_in    = wp_ff;
      ready_in = ready_ff;
      count_in = count_ff;
      q_job    = '0;
      if (req_data.action == asbp_pkg::ACTION_RELEASE) begin
         ready_in[req_data.release_block] = 1'b0;
         q_job.flags = asbp_pkg::FLAG_W'(ready_in);
      end else begin
         q_job.is_write = 1'b1;
         q_job.addr     = wp_ff;
         q_job.data     = req_data.sample;
         if (completes) begin
            ready_in[blk] = 1'b1;
            count_in      = '0;
            wp_in         = {blk_next, {asbp_pkg::OFF_W{1'b0}}};
            q_job.done    = 1'b1;
            q_job.blk     = blk;
            q_job.count   = count_inc;
         end else begin
            count_in = count_inc;
            wp_in    = {blk, off_next};
         end
         q_job.flags = asbp_pkg::FLAG_W'(ready_in);
      end
   end

   // Block state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         ready_ff <= '0;
         count_ff <= '0;
      end else if (q_push) begin
         wp_ff    <= wp_in;
         ready_ff <= ready_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_PROP(a_wp_aligned, clock, reset, wp_ff[1:0] == 2'b00, "pointer not word aligned")
   `ASSERT_PROP(a_wp_below_fill, clock, reset, wp_ff[asbp_pkg::OFF_W-1:0] < asbp_pkg::FILL_OFF, "pointer past fill limit")
   `ASSERT_PROP(a_done_restarts, clock, reset, q_push && q_job.done |=> wp_ff[asbp_pkg::OFF_W-1:0] == '0, "pointer not at block start after completion")

endmodule

[hdl/asbp_queue.sv]
`include "assert_macros.svh"

module asbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  asbp_pkg::job_type q_job,
   output logic              q_full,
   input  logic              q_pop,
   output logic              q_empty,
   output asbp_pkg::job_type q_head
);

   asbp_pkg::job_type slot_ff [asbp_pkg::QUEUE_DEPTH];

   logic [asbp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [asbp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [asbp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign q_full  = (count_ff == asbp_pkg::QCNT_W'(asbp_pkg::QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = slot_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == asbp_pkg::QPTR_W'(asbp_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == asbp_pkg::QPTR_W'(asbp_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_job;
      end
   end

   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= asbp_pkg::QCNT_W'(asbp_pkg::QUEUE_DEPTH), "queue count over depth")
   `ASSERT_PROP(a_push_grows, clock, reset, do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1, "push did not grow queue")
   `ASSERT_PROP(a_pop_shrinks, clock, reset, do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1, "pop did not shrink queue")

endmodule

[hdl/asbp_back.sv]
`include "assert_macros.svh"

module asbp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  asbp_pkg::job_type q_head,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output asbp_pkg::rsp_type rsp_data
);

   asbp_pkg::rsp_type out_ff, out_in;
   asbp_pkg::rsp_type sec_ff, sec_in;
   logic              out_valid_ff, out_valid_in;
   logic              sec_valid_ff, sec_valid_in;
   logic              load;

   asbp_pkg::rsp_type first_word;
   asbp_pkg::rsp_type count_word;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign load     = !out_valid_ff || pop;
   assign q_pop    = load && !sec_valid_ff && !q_empty;

   // Expand a job into its sample word and, on completion, the count byte.
   always_comb begin
      first_word               = '0;
      first_word.write_enable  = q_head.is_write;
      first_word.write_address = q_head.addr;
      first_word.write_data    = q_head.data;
      first_word.block_done    = q_head.done;
      first_word.done_block    = q_head.blk;
      first_word.ready_flags   = q_head.flags;
      first_word.last          = !q_head.done;

      count_word               = '0;
      count_word.write_enable  = 1'b1;
      count_word.write_address = {q_head.blk, asbp_pkg::COUNT_OFF};
      count_word.write_data    = asbp_pkg::SAMPLE_BITS'(q_head.count);
      count_word.write_is_byte = 1'b1;
      count_word.block_done    = 1'b1;
      count_word.done_block    = q_head.blk;
      count_word.ready_flags   = q_head.flags;
      count_word.last          = 1'b1;
   end

   // Output register with a pending second word behind it.
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      sec_in       = sec_ff;
      sec_valid_in = sec_valid_ff;
      if (load) begin
         if (sec_valid_ff) begin
            out_in       = sec_ff;
            out_valid_in = 1'b1;
            sec_valid_in = 1'b0;
         end else if (!q_empty) begin
            out_in       = first_word;
            out_valid_in = 1'b1;
            sec_in       = count_word;
            sec_valid_in = q_head.done;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      sec_ff <= sec_in;
   end

   `ASSERT_PROP(a_sec_behind_out, clock, reset, sec_valid_ff |-> out_valid_ff, "second word without first")
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, q_pop && q_empty, "pop from empty queue")
   `ASSERT_PROP(a_pair_order, clock, reset, sec_valid_ff |-> !out_ff.last && out_ff.block_done, "count byte not after its sample word")

endmodule

[hdl/adc_sample_block_packer.sv]
// Channel  | Ports                        | Word
// ---------+------------------------------+---------------------------------
// request  | push, full, req_data         | asbp_pkg::req_type
// response | empty, pop, rsp_data         | asbp_pkg::rsp_type
//
// A word can be pushed every cycle while full is low; once accepted, it passes
// through the job queue and the output register before it is on rsp_data.
// A sample that completes a block yields two responses, its sample word and
// then the count byte; every other word yields one.
// A four-entry job queue sits between the classifier and the output stage, so a
// stalled pop backs up into full only once that queue has filled.
// Synchronous reset clears the pointer, ready flags, overflow count and queue.
module adc_sample_block_packer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  asbp_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output asbp_pkg::rsp_type rsp_data
);

   asbp_pkg::job_type q_job;
   asbp_pkg::job_type q_head;
   logic              q_push;
   logic              q_pop;
   logic              q_full;
   logic              q_empty;

   assign full = q_full;

   // Front: keeps block state and classifies each word.
   asbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (q_job)
   );

   // Job queue between the two parts.
   asbp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_job   (q_job),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // Back: turns jobs into buffer write responses.
   asbp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

[verif/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import asbp_pkg::*;

   // Clock, reset and the two channels of the block.
   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   // Buffer writes that the packer must still produce, oldest first.
   rsp_type expected_writes[$];
   int unsigned error_count = 0;

   // Our own copy of the packer state.
   int unsigned           fill_ptr = 0;
   logic [NUM_BLOCKS-1:0] block_ready = '0;
   logic [COUNT_W-1:0]    overrun_count = '0;

   // Controls shared by the tests and the pop process.
   bit          no_idle = 1'b0;
   int unsigned pop_hold_cycles = 0;
   int unsigned pop_stall_left = 0;

   adc_sample_block_packer dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // Work out the buffer writes that one accepted word causes and update the state.
   function automatic void predict_writes(req_type w);
      rsp_type     r;
      int unsigned addr;
      int unsigned blk;
      int unsigned off;
      r = '0;
      if (w.action == ACTION_RELEASE) begin
         if (w.release_block < NUM_BLOCKS) begin
            block_ready[w.release_block] = 1'b0;
         end
         r.ready_flags = FLAG_W'(block_ready);
         r.last        = 1'b1;
         expected_writes.push_back(r);
         return;
      end
      addr = fill_ptr;
      // The overflow test looks at the flags before this sample sets one.
      if (&block_ready) begin
         overrun_count++;
      end
      blk = addr / BLOCK_BYTES;
      if (blk >= NUM_BLOCKS) begin
         blk = 0;
      end
      off = addr % BLOCK_BYTES + SAMPLE_BYTES;
      r.write_enable  = 1'b1;
      r.write_address = ADDR_W'(addr);
      r.write_data    = w.sample;
      if (off < FILL_LIMIT) begin
         fill_ptr      = blk * BLOCK_BYTES + off;
         r.ready_flags = FLAG_W'(block_ready);
         r.last        = 1'b1;
         expected_writes.push_back(r);
         return;
      end
      // Block complete: the sample write, then the count as a single byte.
      block_ready[blk] = 1'b1;
      r.block_done  = 1'b1;
      r.done_block  = BLK_W'(blk);
      r.ready_flags = FLAG_W'(block_ready);
      expected_writes.push_back(r);
      r.write_address = ADDR_W'(blk * BLOCK_BYTES + COUNT_OFFSET);
      r.write_data    = SAMPLE_BITS'(overrun_count);
      r.write_is_byte = 1'b1;
      r.last          = 1'b1;
      expected_writes.push_back(r);
      overrun_count = '0;
      blk = blk + 1;
      if (blk >= NUM_BLOCKS) begin
         blk = 0;
      end
      fill_ptr = blk * BLOCK_BYTES;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Compare every popped word against the oldest expected write.
   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_writes.size() == 0) begin
            $display("%0t: no word expected, got %p", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_writes.pop_front();
            check_field("write_enable", want.write_enable, rsp_data.write_enable);
            check_field("write_address", want.write_address, rsp_data.write_address);
            check_field("write_data", want.write_data, rsp_data.write_data);
            check_field("write_is_byte", want.write_is_byte, rsp_data.write_is_byte);
            check_field("block_done", want.block_done, rsp_data.block_done);
            check_field("done_block", want.done_block, rsp_data.done_block);
            check_field("ready_flags", want.ready_flags, rsp_data.ready_flags);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   // Receiver: mostly pops, short stalls, now and then a long one.
   always @(posedge clock) begin : drive_pop
      int unsigned roll;
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_hold_cycles != 0) begin
         pop <= 1'b0;
         pop_hold_cycles--;
      end else if (no_idle) begin
         pop <= 1'b1;
      end else if (pop_stall_left != 0) begin
         pop <= 1'b0;
         pop_stall_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            pop <= 1'b1;
         end else begin
            pop <= 1'b0;
            pop_stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
   end

   function automatic int unsigned sender_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 75) begin
         return 0;
      end
      return (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
   endfunction

   task automatic idle_sender(int unsigned n);
      if (n != 0) begin
         push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one word, wait until it is taken, then predict its writes.
   task automatic send_word(req_type w);
      push     <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (full);
      predict_writes(w);
      idle_sender(sender_gap());
   endtask

   task automatic send_sample(logic [SAMPLE_BITS-1:0] value, logic [BLK_W-1:0] blk);
      req_type w;
      w.action        = ACTION_SAMPLE;
      w.sample        = value;
      w.release_block = blk;
      send_word(w);
   endtask

   task automatic send_release(logic [BLK_W-1:0] blk, logic [SAMPLE_BITS-1:0] value);
      req_type w;
      w.action        = ACTION_RELEASE;
      w.sample        = value;
      w.release_block = blk;
      send_word(w);
   endtask

   // Sender stops and waits until every expected write has come out.
   task automatic drain_writes();
      push <= 1'b0;
      @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
   endtask

   // Extreme sample values and a release of every block while none is ready.
   task automatic test_directed();
      send_sample(32'h0000_0000, 2'd0);
      send_sample(32'hFFFF_FFFF, 2'd3);
      send_sample(32'h8000_0001, 2'd1);
      send_sample(32'h7FFF_FFFE, 2'd2);
      send_sample(32'hA5A5_5A5A, 2'd0);
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         send_release(BLK_W'(b), (b % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000);
      end
      send_sample(32'h0000_0001, 2'd3);
      send_sample(32'hFFFF_FFFE, 2'd0);
      drain_writes();
   endtask

   // Fill every block so that all are ready, then keep writing: the count grows
   // and goes out with two more completions, the pointer wraps to block zero.
   task automatic test_overflow_count();
      int unsigned completions;
      while (!(&block_ready)) begin
         send_sample($urandom, BLK_W'($urandom));
      end
      completions = 0;
      while (completions < 2) begin
         if ((fill_ptr % BLOCK_BYTES) + SAMPLE_BYTES >= FILL_LIMIT) begin
            completions++;
         end
         send_sample($urandom, BLK_W'($urandom));
      end
      drain_writes();
      // Free the blocks again, one of them twice.
      for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
         send_release(BLK_W'(b), $urandom);
      end
      send_release(2'd0, $urandom);
      drain_writes();
   endtask

   // The receiver holds off while the sender keeps offering words back to back.
   task automatic test_backpressure();
      no_idle = 1'b1;
      pop_hold_cycles = 300;
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_release(BLK_W'($urandom), $urandom);
         end else begin
            send_sample($urandom, BLK_W'($urandom));
         end
      end
      drain_writes();
      no_idle = 1'b0;
   endtask

   // Mostly samples with random content, releases of random blocks in between.
   task automatic test_random_traffic(int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         no_idle = (i < 80);
         if ($urandom_range(0, 99) < 12) begin
            send_release(BLK_W'($urandom), $urandom);
         end else begin
            send_sample($urandom, BLK_W'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_overflow_count();
      test_backpressure();
      test_random_traffic(400);
      drain_writes();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
